/* sv/mvfc_pkg.sv */
package mvfc_pkg;

  typedef enum logic [1:0] {
    CMD_PULSE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2,
    CMD_OPEN  = 2'd3
  } cmd_t;

  localparam logic [15:0] MAX_FLOW_RESET = 16'd1000;
  localparam logic [15:0] TARGET_RESET   = 16'd500;
  localparam logic [15:0] MOVE_THRESHOLD = 16'd300;
  localparam logic [15:0] MIN_TARGET     = 16'd100;
  localparam logic [15:0] POT_FULL_SCALE = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  // 2000/540 reduces to 100/27; one pulse adds 3 to the quotient, 19 to the remainder
  localparam logic [17:0] RATE_STEP_Q = 18'd3;
  localparam logic [5:0]  RATE_STEP_R = 6'd19;
  localparam logic [5:0]  RATE_DEN    = 6'd27;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] sample;
    logic [15:0] raw;
  } item_t;

endpackage

/* sv/mvfc_scale.sv */
module mvfc_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         max_flow,
  input  logic                in_valid,
  output logic                in_ready,
  input  mvfc_pkg::cmd_t      command,
  input  logic [15:0]         pot_sample,
  output logic                item_valid,
  input  logic                item_ready,
  output mvfc_pkg::item_t     item
);

  logic                v1;
  mvfc_pkg::cmd_t      cmd1;
  logic [15:0]         smp1;
  logic                v2;
  mvfc_pkg::cmd_t      cmd2;
  logic [15:0]         smp2;
  logic [31:0]         prod2;

  logic                en1;
  logic                en2;
  logic [31:0]         prod;
  logic [15:0]         q0;
  logic [16:0]         r0;
  logic [15:0]         raw;

  assign en2      = !v2 || item_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign prod = 32'(smp1) * 32'(max_flow);

  // divide by 65535: p/65536 plus one correction step
  assign q0  = prod2[31:16];
  assign r0  = {1'b0, prod2[15:0]} + {1'b0, q0};
  assign raw = (r0 >= {1'b0, mvfc_pkg::POT_FULL_SCALE}) ? q0 + 16'd1 : q0;

  assign item_valid = v2;
  assign item       = {cmd2, smp2, raw};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      cmd1 <= command;
      smp1 <= pot_sample;
    end
    if (en2 && v1) begin
      cmd2  <= cmd1;
      smp2  <= smp1;
      prod2 <= prod;
    end
  end

endmodule

/* sv/mvfc_core.sv */
module mvfc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mvfc_pkg::item_t     item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                valve_open,
  output logic [17:0]         flow_rate_ml,
  output logic [31:0]         total_flow_ml,
  output logic [15:0]         target_ml,
  output logic                done_res
);

  logic        ovalid;
  logic        done;
  logic [15:0] pulse_count, pulse_count_next;
  logic [17:0] rate_q, rate_q_next;
  logic [4:0]  rate_r, rate_r_next;
  logic [15:0] last_pot, last_pot_next;
  logic [17:0] rate_reg, rate_reg_next;
  logic [31:0] total_reg, total_reg_next;
  logic [15:0] target_reg, target_reg_next;
  logic        valve_reg, valve_reg_next;
  logic        done_next;

  logic        en;
  logic        take;
  logic [15:0] diff;
  logic        moved;
  logic [15:0] target_mid;
  logic        valve_mid;
  logic [32:0] sum;
  logic [31:0] total_tick;
  logic        done_tick;
  logic [5:0]  rsum;

  assign en         = !ovalid || out_ready;
  assign item_ready = en;
  assign take       = en && item_valid;

  assign diff  = (item.sample > last_pot) ? item.sample - last_pot : last_pot - item.sample;
  assign moved = diff >= mvfc_pkg::MOVE_THRESHOLD;

  assign target_mid = !moved ? target_reg :
                      (item.raw < mvfc_pkg::MIN_TARGET) ? 16'd0 : item.raw;
  assign valve_mid  = !moved ? valve_reg : (total_reg < {16'd0, item.raw});

  assign sum        = {1'b0, total_reg} + {15'd0, rate_q};
  assign total_tick = sum[32] ? '1 : sum[31:0];
  assign done_tick  = total_tick >= {16'd0, target_mid};

  assign rsum = {1'b0, rate_r} + mvfc_pkg::RATE_STEP_R;

  always_comb begin
    pulse_count_next = pulse_count;
    rate_q_next      = rate_q;
    rate_r_next      = rate_r;
    last_pot_next    = last_pot;
    rate_reg_next    = rate_reg;
    total_reg_next   = total_reg;
    target_reg_next  = target_reg;
    valve_reg_next   = valve_reg;
    done_next        = 1'b0;
    unique case (item.cmd)
      mvfc_pkg::CMD_PULSE: begin
        if (pulse_count != mvfc_pkg::COUNT_MAX) begin
          pulse_count_next = pulse_count + 16'd1;
          if (rsum >= mvfc_pkg::RATE_DEN) begin
            rate_r_next = 5'(rsum - mvfc_pkg::RATE_DEN);
            rate_q_next = rate_q + mvfc_pkg::RATE_STEP_Q + 18'd1;
          end else begin
            rate_r_next = rsum[4:0];
            rate_q_next = rate_q + mvfc_pkg::RATE_STEP_Q;
          end
        end
      end
      mvfc_pkg::CMD_TICK: begin
        last_pot_next    = item.sample;
        target_reg_next  = target_mid;
        rate_reg_next    = rate_q;
        total_reg_next   = total_tick;
        done_next        = done_tick;
        valve_reg_next   = done_tick ? 1'b0 : valve_mid;
        pulse_count_next = 16'd0;
        rate_q_next      = 18'd0;
        rate_r_next      = 5'd0;
      end
      mvfc_pkg::CMD_START: begin
        pulse_count_next = 16'd0;
        rate_q_next      = 18'd0;
        rate_r_next      = 5'd0;
        rate_reg_next    = 18'd0;
        total_reg_next   = 32'd0;
        if (target_reg != 16'd0) valve_reg_next = 1'b1;
      end
      mvfc_pkg::CMD_OPEN: begin
        valve_reg_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid      <= 1'b0;
      pulse_count <= 16'd0;
      rate_q      <= 18'd0;
      rate_r      <= 5'd0;
      last_pot    <= 16'd0;
      rate_reg    <= 18'd0;
      total_reg   <= 32'd0;
      target_reg  <= mvfc_pkg::TARGET_RESET;
      valve_reg   <= 1'b0;
    end else begin
      if (en) ovalid <= item_valid;
      if (take) begin
        pulse_count <= pulse_count_next;
        rate_q      <= rate_q_next;
        rate_r      <= rate_r_next;
        last_pot    <= last_pot_next;
        rate_reg    <= rate_reg_next;
        total_reg   <= total_reg_next;
        target_reg  <= target_reg_next;
        valve_reg   <= valve_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) done <= done_next;
  end

  assign out_valid     = ovalid;
  assign valve_open    = valve_reg;
  assign flow_rate_ml  = rate_reg;
  assign total_flow_ml = total_reg;
  assign target_ml     = target_reg;
  assign done_res      = done;

endmodule

/* sv/metered_valve_flow_controller.sv */
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   command, pot_sample
// out      output     out_valid / out_ready valve_open, flow_rate_ml, total_flow_ml,
//                                           target_ml, done_res
// cfg      input      cfg_valid / cfg_ready cfg_data (full-scale volume)
//
// one word per cycle sustained while out_ready stays high; a result is registered in order through
// the input register, the product register and the divide-by-65535 correction and state update
// reset empties all stages and restores full scale 1000 and target 500
// out_ready low holds the result; the stages behind it fill and in_ready drops
// cfg_ready is always high
module metered_valve_flow_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] pot_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        valve_open,
  output logic [17:0] flow_rate_ml,
  output logic [31:0] total_flow_ml,
  output logic [15:0] target_ml,
  output logic        done_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]     full_scale_ml;
  logic            item_valid;
  logic            item_ready;
  mvfc_pkg::item_t item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_ml <= mvfc_pkg::MAX_FLOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      full_scale_ml <= cfg_data;
    end
  end

  mvfc_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .max_flow   (full_scale_ml),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (mvfc_pkg::cmd_t'(command)),
    .pot_sample (pot_sample),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  mvfc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valve_open    (valve_open),
    .flow_rate_ml  (flow_rate_ml),
    .total_flow_ml (total_flow_ml),
    .target_ml     (target_ml),
    .done_res      (done_res)
  );

endmodule

/* sv/mvfc_checker.sv */
module mvfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valve_open,
  input logic        done_res,
  input logic [31:0] total_flow_ml,
  input logic [15:0] target_ml
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_flow_ml) && $stable(target_ml)
      && $stable(valve_open) && $stable(done_res))
    else $error("stalled result word changed");

  a_done_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !valve_open)
    else $error("done reported with valve open");

  a_done_reached: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> total_flow_ml >= {16'd0, target_ml})
    else $error("done reported below target");

endmodule

bind metered_valve_flow_controller mvfc_checker u_mvfc_checker (.*);

/* tb/sv/tb_metered_valve_flow_controller.sv */
`timescale 1ns / 100ps

module tb_metered_valve_flow_controller;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [31:0] FLOW_PER_PULSE_NUM = 32'd2000;
  localparam logic [31:0] FLOW_PER_PULSE_DEN = 32'd540;

  typedef enum logic {
    WORD_IN,
    WORD_CFG
  } word_kind_t;

  typedef struct {
    word_kind_t     kind;
    mvfc_pkg::cmd_t cmd;
    logic [15:0]    sample;
    logic [15:0]    scale;
    int             gap;
    bit             calm;
  } pending_word_t;

  typedef struct packed {
    logic        valve;
    logic [17:0] rate;
    logic [31:0] total;
    logic [15:0] target;
    logic        done;
  } valve_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = mvfc_pkg::CMD_PULSE;
  logic [15:0] pot_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        valve_open;
  logic [17:0] flow_rate_ml;
  logic [31:0] total_flow_ml;
  logic [15:0] target_ml;
  logic        done_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // predicted controller state
  logic [15:0] full_scale = mvfc_pkg::MAX_FLOW_RESET;
  logic [15:0] pulses = '0;
  logic [15:0] prev_pot = '0;
  logic [17:0] rate_now = '0;
  logic [31:0] volume = '0;
  logic [15:0] target_now = mvfc_pkg::TARGET_RESET;
  logic        valve_now = 1'b0;

  pending_word_t pending[$];
  valve_status_t status_queue[$];
  int          hold = 0;
  int          stall = 0;
  int          mismatches = 0;
  int          random_words = 0;
  int          gen_pot = 0;
  int unsigned cycles = 0;
  bit          steady_flow = 1'b0;

  metered_valve_flow_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .pot_sample    (pot_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valve_open    (valve_open),
    .flow_rate_ml  (flow_rate_ml),
    .total_flow_ml (total_flow_ml),
    .target_ml     (target_ml),
    .done_res      (done_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic valve_status_t step_valve(mvfc_pkg::cmd_t cmd, logic [15:0] sample);
    logic [15:0]   diff;
    logic [31:0]   raw;
    logic [32:0]   sum;
    valve_status_t res;
    res.done = 1'b0;
    case (cmd)
      mvfc_pkg::CMD_PULSE: begin
        if (pulses != mvfc_pkg::COUNT_MAX) pulses = pulses + 16'd1;
      end
      mvfc_pkg::CMD_TICK: begin
        diff = (sample > prev_pot) ? sample - prev_pot : prev_pot - sample;
        prev_pot = sample;
        if (diff >= mvfc_pkg::MOVE_THRESHOLD) begin
          raw = ({16'd0, sample} * {16'd0, full_scale}) / {16'd0, mvfc_pkg::POT_FULL_SCALE};
          target_now = (raw < {16'd0, mvfc_pkg::MIN_TARGET}) ? 16'd0 : raw[15:0];
          valve_now = (volume >= raw) ? 1'b0 : 1'b1;
        end
        raw = (FLOW_PER_PULSE_NUM * {16'd0, pulses}) / FLOW_PER_PULSE_DEN;
        rate_now = raw[17:0];
        sum = {1'b0, volume} + {15'd0, rate_now};
        volume = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (volume >= {16'd0, target_now}) begin
          valve_now = 1'b0;
          res.done = 1'b1;
        end
        pulses = '0;
      end
      mvfc_pkg::CMD_START: begin
        pulses = '0;
        rate_now = '0;
        volume = '0;
        if (target_now != 16'd0) valve_now = 1'b1;
      end
      default: begin
        valve_now = 1'b1;
      end
    endcase
    res.valve = valve_now;
    res.rate = rate_now;
    res.total = volume;
    res.target = target_now;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] next_sample();
    int s;
    int d;
    d = -1;
    s = 0;
    case ($urandom_range(0, 9))
      0: s = 0;
      1: s = 65535;
      2: d = 300;
      3: d = 299;
      4, 5: d = $urandom_range(0, 60);
      default: s = $urandom_range(0, 65535);
    endcase
    if (d >= 0) begin
      s = $urandom_range(0, 1) ? gen_pot + d : gen_pot - d;
      if (s > 65535) s = gen_pot - d;
      if (s < 0) s = gen_pot + d;
    end
    return 16'(s);
  endfunction

  task automatic add_word(mvfc_pkg::cmd_t cmd, logic [15:0] sample, bit calm);
    pending_word_t w;
    w.kind = WORD_IN;
    w.cmd = cmd;
    w.sample = sample;
    w.scale = '0;
    w.gap = calm ? 0 : pick_gap();
    w.calm = calm;
    pending.push_back(w);
    if (cmd == mvfc_pkg::CMD_TICK) gen_pot = sample;
    random_words++;
  endtask

  task automatic add_cfg(logic [15:0] scale);
    pending_word_t w;
    w.kind = WORD_CFG;
    w.cmd = mvfc_pkg::CMD_PULSE;
    w.sample = '0;
    w.scale = scale;
    w.gap = pick_gap();
    w.calm = 1'b0;
    pending.push_back(w);
  endtask

  // one watering run: start, bursts of pulses (sometimes with an open) closed by ticks, or a few stray words
  task automatic add_cycle(bit calm);
    int n;
    if ($urandom_range(0, 9) < 8) begin
      add_word(mvfc_pkg::CMD_START, 16'($urandom), calm);
      repeat ($urandom_range(1, 6)) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 150) : $urandom_range(0, 12);
        repeat (n) add_word(mvfc_pkg::CMD_PULSE, 16'($urandom), calm);
        if ($urandom_range(0, 7) == 0) add_word(mvfc_pkg::CMD_OPEN, 16'($urandom), calm);
        add_word(mvfc_pkg::CMD_TICK, next_sample(), calm);
      end
    end else begin
      repeat ($urandom_range(1, 6))
        add_word(mvfc_pkg::cmd_t'($urandom_range(0, 3)), 16'($urandom), calm);
    end
  endtask

  always @(posedge clk) begin : drive_words
    pending_word_t w;
    logic          busy;
    logic          send_in;
    logic          send_cfg;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      hold = 0;
    end else begin
      busy = 1'b0;
      if (in_valid) begin
        if (in_ready) status_queue.push_back(step_valve(mvfc_pkg::cmd_t'(command), pot_sample));
        else busy = 1'b1;
      end
      if (cfg_valid) begin
        if (cfg_ready) full_scale = cfg_data;
        else busy = 1'b1;
      end
      if (!busy) begin
        send_in = 1'b0;
        send_cfg = 1'b0;
        if (hold > 0) begin
          hold--;
        end else if (pending.size() > 0) begin
          w = pending[0];
          // registers only change with nothing in flight
          if (w.kind == WORD_IN) send_in = 1'b1;
          else if (status_queue.size() == 0) send_cfg = 1'b1;
          if (send_in || send_cfg) begin
            void'(pending.pop_front());
            hold = w.gap;
            steady_flow <= w.calm;
            if (send_in) begin
              command <= w.cmd;
              pot_sample <= w.sample;
            end else begin
              cfg_data <= w.scale;
            end
          end
        end
        in_valid <= send_in;
        cfg_valid <= send_cfg;
      end
    end
  end

  always @(posedge clk) begin : check_results
    valve_status_t got;
    valve_status_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.valve = valve_open;
        got.rate = flow_rate_ml;
        got.total = total_flow_ml;
        got.target = target_ml;
        got.done = done_res;
        if (status_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: valve %0d rate %0d total %0d target %0d done %0d",
                     got.valve, got.rate, got.total, got.target, got.done);
        end else begin
          want = status_queue.pop_front();
          if (got.valve !== want.valve || got.rate !== want.rate ||
              got.total !== want.total || got.target !== want.target ||
              got.done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected valve %0d rate %0d total %0d target %0d done %0d,",
                        " got valve %0d rate %0d total %0d target %0d done %0d"},
                       want.valve, want.rate, want.total, want.target, want.done,
                       got.valve, got.rate, got.total, got.target, got.done);
          end
        end
      end
      if (stall == 0 && !steady_flow && $urandom_range(0, 3) == 0) stall = pick_gap();
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL metered_valve_flow_controller");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    logic [15:0] scale;

    // directed words at the reset full scale of 1000
    add_word(mvfc_pkg::CMD_TICK, 16'd0, 1'b0);
    add_word(mvfc_pkg::CMD_START, 16'hFFFF, 1'b0);
    repeat (3) add_word(mvfc_pkg::CMD_PULSE, 16'h5555, 1'b0);
    add_word(mvfc_pkg::CMD_TICK, 16'd299, 1'b0);
    add_word(mvfc_pkg::CMD_TICK, 16'd65535, 1'b0);
    add_word(mvfc_pkg::CMD_OPEN, 16'hAAAA, 1'b0);
    add_word(mvfc_pkg::CMD_TICK, 16'd65235, 1'b0);
    // zero target: tick closes and reports done, start leaves the valve alone
    add_word(mvfc_pkg::CMD_TICK, 16'd0, 1'b0);
    add_word(mvfc_pkg::CMD_START, 16'd0, 1'b0);
    add_word(mvfc_pkg::CMD_OPEN, 16'd0, 1'b0);
    add_word(mvfc_pkg::CMD_TICK, 16'd0, 1'b0);
    // targets just under and over the minimum
    add_word(mvfc_pkg::CMD_TICK, 16'd6553, 1'b0);
    add_word(mvfc_pkg::CMD_TICK, 16'd6900, 1'b0);
    add_cfg(16'hFFFF);
    add_word(mvfc_pkg::CMD_TICK, 16'd65535, 1'b0);
    add_word(mvfc_pkg::CMD_START, 16'd0, 1'b0);
    add_word(mvfc_pkg::CMD_PULSE, 16'd0, 1'b0);
    add_word(mvfc_pkg::CMD_TICK, 16'd65535, 1'b0);
    add_cfg(16'd0);
    add_word(mvfc_pkg::CMD_TICK, 16'd0, 1'b0);
    add_word(mvfc_pkg::CMD_TICK, 16'd65535, 1'b0);
    add_cfg(mvfc_pkg::MAX_FLOW_RESET);

    random_words = 0;
    phase = 0;
    while (random_words < 600) begin
      case (phase % 6)
        0: scale = 16'hFFFF;
        1: scale = 16'd0;
        2: scale = mvfc_pkg::MAX_FLOW_RESET;
        3: scale = 16'($urandom_range(1, 120));
        4: scale = 16'($urandom_range(200, 4000));
        default: scale = 16'($urandom);
      endcase
      add_cfg(scale);
      while (random_words < (phase + 1) * 100) add_cycle(phase % 3 == 2);
      phase++;
    end

    while (rst) @(posedge clk);
    while (pending.size() != 0 || in_valid || cfg_valid || status_queue.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && status_queue.size() == 0) begin
      $display("PASS metered_valve_flow_controller");
    end else begin
      $display("FAIL metered_valve_flow_controller");
    end
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
